// File: src/fpbd_pkg.sv
package fpbd_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_BITCELL = 2'd0;
    localparam logic [1:0] REG_SCALE   = 2'd1;
    localparam logic [1:0] REG_ADJUST  = 2'd2;
    localparam logic [1:0] REG_PHASE   = 2'd3;

    // Field and register widths
    localparam int unsigned FLUX_W    = 16;
    localparam int unsigned BITCELL_W = 14;
    localparam int unsigned SCALE_W   = 8;
    localparam int unsigned ADJ_W     = 6;
    localparam int unsigned PHPCT_W   = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 14;
    localparam int unsigned OUT_DAT_W = 8;
    localparam int unsigned OUT_USR_W = 2;

    // Reset values of the registers
    localparam logic [BITCELL_W-1:0] RST_BITCELL = 14'd2000;
    localparam logic [SCALE_W-1:0]   RST_SCALE   = 8'd100;
    localparam logic [ADJ_W-1:0]     RST_ADJUST  = 6'd4;
    localparam logic [PHPCT_W-1:0]   RST_PHASE   = 7'd60;

    // Decoder constants
    localparam int unsigned MAX_CELLS               = 32;
    localparam int unsigned GOOD_BITS_BEFORE_REPORT = 256;
    localparam int unsigned MAX_IN_SYNC_ZEROS       = 3;
    localparam int unsigned STEP_RESULT_CAP         = 40;
    localparam int unsigned GOOD_SAT                = 256;
    localparam int unsigned ZRUN_SAT                = 7;

    localparam int unsigned CNT_W   = $clog2(STEP_RESULT_CAP + 1);
    localparam int unsigned GOOD_W  = $clog2(GOOD_SAT + 1);
    localparam int unsigned ZRUN_W  = $clog2(ZRUN_SAT + 1);
    localparam int unsigned ACC_W   = 24;
    localparam int unsigned CLK_W   = 15;  // cmax never exceeds 16383 * 163 / 100
    localparam int unsigned CMIN_W  = 14;
    localparam int unsigned LIMIT_W = CMIN_W + $clog2(MAX_CELLS + 1);

    // x / 100 as (x * ceil(2^31 / 100)) >> 31, exact for x below 2^24
    localparam int unsigned    RECIP_SHIFT = 31;
    localparam logic [24:0]    RECIP_100   = 25'd21474837;

    // Controller commands
    typedef struct packed {
        logic load;   // input transfer, latch interval
        logic scale;  // form the scale and clamp products
        logic div;    // divide the products by 100
        logic add;    // saturate interval and add it to the phase
        logic step;   // clock out one cell
        logic mul;    // PLL products for a one cell
        logic quo;    // divide the PLL products by 100
        logic upd;    // update clock and phase, one cell out
        logic emit;   // load the output register
        logic last;   // final cell of this input
    } t_cmd;

    // Datapath status
    typedef struct packed {
        logic run;       // phase holds at least half a clock
        logic zero;      // the cell being clocked is a zero
        logic out_free;  // output register can take a result
    } t_status;

    function automatic logic [17:0] div100(input logic [23:0] x);
        logic [48:0] p;
        p = {25'd0, x} * {24'd0, RECIP_100};
        return p[48:RECIP_SHIFT];
    endfunction

    // Signed divide by 100, truncating toward zero
    function automatic logic signed [18:0] sdiv100(input logic signed [23:0] x);
        logic [23:0] mag;
        logic [17:0] q;
        mag = x[23] ? 24'(-x) : 24'(x);
        q   = div100(mag);
        return x[23] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Clamp a 25-bit sum to the 24-bit signed range
    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        logic signed [23:0] r;
        if (v[24] != v[23]) begin
            r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// File: src/fpbd_ctrl.sv
module fpbd_ctrl
    import fpbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_ADD   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_QUO   = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_cap;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_cap      = (r_cnt == CNT_W'(STEP_RESULT_CAP - 1));

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                n_state = i_status.run ? S_STEP : S_IDLE;
            end
            S_STEP: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.zero) begin
                        // zero cell goes out now; the loop goes on until the cap
                        o_cmd.emit = 1'b1;
                        o_cmd.last = w_cap;
                        n_cnt      = r_cnt + 1'b1;
                        n_state    = w_cap ? S_IDLE : S_STEP;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_QUO;
            end
            S_QUO: begin
                o_cmd.quo = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    o_cmd.upd  = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: src/fpbd_dpath.sv
module fpbd_dpath
    import fpbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input payload
    input  logic [FLUX_W-1:0]    i_flux_ns,
    input  logic                 i_new_revolution,
    // output register
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_data_bit,
    output logic                 o_index_seen,
    output logic                 o_sync_lost_flag,
    output logic                 o_last_of_run,
    // control
    input  t_cmd                 i_cmd,
    output t_status              o_status
);

    // Configuration registers
    logic [BITCELL_W-1:0] r_bitcell;
    logic [SCALE_W-1:0]   r_scale;
    logic [ADJ_W-1:0]     r_adj;
    logic [PHPCT_W-1:0]   r_phpct;

    // Per-item working registers
    logic [FLUX_W-1:0]   r_flux;
    logic [23:0]         r_prod_flux;
    logic [20:0]         r_prod_min;
    logic [21:0]         r_prod_max;
    logic [17:0]         r_flux_s;
    logic [CMIN_W-1:0]   r_cmin;
    logic [CLK_W-1:0]    r_cmax;
    logic signed [22:0]  r_prod_clk;
    logic signed [23:0]  r_prod_ph;
    logic signed [18:0]  r_dq_clk;
    logic signed [18:0]  r_dq_ph;

    // Decoder state
    logic signed [ACC_W-1:0] r_phase;
    logic [CLK_W-1:0]        r_clock;
    logic [ZRUN_W-1:0]       r_zero_run;
    logic [GOOD_W-1:0]       r_good;
    logic                    r_index_pend;
    logic                    r_sync_pend;

    // Output register
    logic r_out_valid, r_out_bit, r_out_index, r_out_sync, r_out_last;

    logic [6:0]               w_fmin;
    logic [7:0]               w_fmax;
    logic [LIMIT_W-1:0]       w_limit;
    logic [LIMIT_W-1:0]       w_flux_lim;
    logic signed [ACC_W-1:0]  w_half;
    logic signed [ACC_W-1:0]  n_phase_add;
    logic signed [ACC_W-1:0]  n_phase_step;
    logic signed [15:0]       w_ph16;
    logic signed [15:0]       w_ctr_err;
    logic signed [15:0]       w_mul_a;
    logic signed [7:0]        w_fph;
    logic                     w_in_sync;
    logic                     w_sync_new;
    logic signed [19:0]       w_clk_sum;
    logic [CLK_W-1:0]         n_clock;

    // Clamp factors
    assign w_fmin = 7'd100 - {1'b0, r_adj};
    assign w_fmax = 8'd100 + {2'b00, r_adj};

    // Interval limit and phase intake
    assign w_limit    = LIMIT_W'(r_cmin) * LIMIT_W'(MAX_CELLS);
    assign w_flux_lim = (LIMIT_W'(r_flux_s) > w_limit) ? w_limit : LIMIT_W'(r_flux_s);
    assign n_phase_add = sat24($signed({r_phase[ACC_W-1], r_phase})
                               + $signed({1'b0, (ACC_W - LIMIT_W)'(0), w_flux_lim}));

    // One cell: take a clock off the phase and compare with half a clock
    assign w_half       = $signed({(ACC_W - CLK_W + 1)'(0), r_clock[CLK_W-1:1]});
    assign n_phase_step = sat24($signed({r_phase[ACC_W-1], r_phase})
                                - $signed({(ACC_W - CLK_W + 1)'(0), r_clock}));

    // On a one cell the phase lies within half a clock, so 16 bits carry it
    assign w_ph16    = r_phase[15:0];
    assign w_ctr_err = $signed({2'b00, r_bitcell}) - $signed({1'b0, r_clock});
    assign w_in_sync = (r_zero_run <= ZRUN_W'(MAX_IN_SYNC_ZEROS));
    assign w_mul_a   = w_in_sync ? w_ph16 : w_ctr_err;
    assign w_fph     = 8'sd100 - $signed({1'b0, r_phpct});
    assign w_sync_new = !w_in_sync && (r_good >= GOOD_W'(GOOD_BITS_BEFORE_REPORT));

    // Clock update, clamped to the adjust range
    always_comb begin
        w_clk_sum = $signed({5'd0, r_clock}) + $signed({r_dq_clk[18], r_dq_clk});
        if (w_clk_sum < $signed({6'd0, r_cmin})) begin
            n_clock = CLK_W'(r_cmin);
        end else if (w_clk_sum > $signed({5'd0, r_cmax})) begin
            n_clock = r_cmax;
        end else begin
            n_clock = w_clk_sum[CLK_W-1:0];
        end
    end

    // Status to the controller
    assign o_status.run      = (r_phase >= w_half);
    assign o_status.zero     = (n_phase_step >= w_half);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Arithmetic registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_flux <= i_flux_ns;
        end
        if (i_cmd.scale) begin
            r_prod_flux <= {8'd0, r_flux} * {16'd0, r_scale};
            r_prod_min  <= {7'd0, r_bitcell} * {14'd0, w_fmin};
            r_prod_max  <= {8'd0, r_bitcell} * {14'd0, w_fmax};
        end
        if (i_cmd.div) begin
            r_flux_s <= div100(r_prod_flux);
            r_cmin   <= CMIN_W'(div100({3'd0, r_prod_min}));
            r_cmax   <= CLK_W'(div100({2'd0, r_prod_max}));
        end
        if (i_cmd.mul) begin
            r_prod_clk <= 23'(w_mul_a) * 23'($signed({1'b0, r_adj}));
            r_prod_ph  <= 24'(w_ph16) * 24'(w_fph);
        end
        if (i_cmd.quo) begin
            r_dq_clk <= sdiv100($signed({r_prod_clk[22], r_prod_clk}));
            r_dq_ph  <= sdiv100(r_prod_ph);
        end
        if (i_cmd.emit) begin
            r_out_bit   <= i_cmd.upd;
            r_out_index <= r_index_pend;
            r_out_sync  <= r_sync_pend || (i_cmd.upd && w_sync_new);
            r_out_last  <= i_cmd.last;
        end
    end

    // Configuration and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitcell    <= RST_BITCELL;
            r_scale      <= RST_SCALE;
            r_adj        <= RST_ADJUST;
            r_phpct      <= RST_PHASE;
            r_phase      <= '0;
            r_clock      <= CLK_W'(RST_BITCELL);
            r_zero_run   <= '0;
            r_good       <= '0;
            r_index_pend <= 1'b0;
            r_sync_pend  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BITCELL: begin
                        r_bitcell <= i_cfg_data[BITCELL_W-1:0];
                        r_clock   <= CLK_W'(i_cfg_data[BITCELL_W-1:0]);
                    end
                    REG_SCALE:  r_scale <= i_cfg_data[SCALE_W-1:0];
                    REG_ADJUST: r_adj   <= i_cfg_data[ADJ_W-1:0];
                    REG_PHASE:  r_phpct <= i_cfg_data[PHPCT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.load && i_new_revolution) begin
                r_index_pend <= 1'b1;
            end

            if (i_cmd.add) begin
                r_phase    <= n_phase_add;
                r_zero_run <= '0;
            end

            // zero cell: count it; one cell waits for the PLL update
            if (i_cmd.step) begin
                r_phase <= n_phase_step;
                if (o_status.zero) begin
                    if (r_zero_run != ZRUN_W'(ZRUN_SAT)) begin
                        r_zero_run <= r_zero_run + 1'b1;
                    end
                    if (r_good < GOOD_W'(GOOD_SAT)) begin
                        r_good <= r_good + 1'b1;
                    end
                end
            end

            // PLL update on a one cell; out of sync the good count restarts at one
            if (i_cmd.upd) begin
                r_clock <= n_clock;
                r_phase <= ACC_W'(r_dq_ph);
                if (w_in_sync) begin
                    if (r_good < GOOD_W'(GOOD_SAT)) begin
                        r_good <= r_good + 1'b1;
                    end
                end else begin
                    r_good <= GOOD_W'(1);
                end
            end

            // pending flags go out with the next cell
            if (i_cmd.emit) begin
                r_index_pend <= 1'b0;
                r_sync_pend  <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_bit       = r_out_bit;
    assign o_index_seen     = r_out_index;
    assign o_sync_lost_flag = r_out_sync;
    assign o_last_of_run    = r_out_last;

endmodule

// File: src/flux_pll_bit_decoder_top.sv
// Channel   Dir  Handshake                      Payload
// -------   ---  -----------------------------  -------------------------------------------
// input     in   s_axis_tvalid / s_axis_tready  tdata: flux_ns; tuser: new_revolution
// output    out  m_axis_tvalid / m_axis_tready  tdata: data_bit; tuser: index, sync; tlast
// config    in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// An input passes through intake (transfer, scale multiply, divide by 100,
// phase add, run check), then the step state per zero cell and the states step,
// PLL multiply, divide by 100 and update per one cell.
// Inputs are taken one at a time; a stalled output holds the cell loop.
// Reset is synchronous, active low, and loads the default register values.
module flux_pll_bit_decoder_top
    import fpbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input intervals
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [FLUX_W-1:0]    s_axis_tdata,   // [15:0] flux_ns
    input  logic                 s_axis_tuser,   // [0] new_revolution
    // decoded cells
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_DAT_W-1:0] m_axis_tdata,   // [0] data_bit, [7:1] zero
    output logic [OUT_USR_W-1:0] m_axis_tuser,   // [0] index_seen, [1] sync_lost_flag
    output logic                 m_axis_tlast,   // last_of_run
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_data_bit;
    logic    w_index_seen;
    logic    w_sync_drop;

    assign o_cfg_ready = 1'b1;

    fpbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fpbd_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_flux_ns        (s_axis_tdata),
        .i_new_revolution (s_axis_tuser),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_data_bit       (w_data_bit),
        .o_index_seen     (w_index_seen),
        .o_sync_lost_flag (w_sync_drop),
        .o_last_of_run    (m_axis_tlast),
        .i_cmd            (w_cmd),
        .o_status         (w_status)
    );

    assign m_axis_tdata = {(OUT_DAT_W - 1)'(0), w_data_bit};
    assign m_axis_tuser = {w_sync_drop, w_index_seen};

`ifndef SYNTHESIS
    // a one cell always ends the run
    a_one_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[0] == 1'b0)
        else $error("one cell without tlast");

    // one input at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("output register overwritten");
`endif

endmodule
